// File: hdl/mlsp_pkg.sv
// Shared types, codes and constants for the MPLS label stack parser.
`default_nettype none
package mlsp_pkg;

  localparam int MAX_LABELS_DEF = 16;
  localparam logic [4:0] MAX_DEPTH_RST = 5'd16;
  localparam int Q_DEPTH = 4;
  localparam int DATA_W = 48;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_TOO_DEEP  = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_IPV4_NULL = 3'd0,
    CLS_RTR_ALERT = 3'd1,
    CLS_IPV6_NULL = 3'd2,
    CLS_IMPL_NULL = 3'd3,
    CLS_OTHER     = 3'd4
  } cls_t;

  // One queued job: an optional label entry and an optional frame status.
  typedef struct packed {
    logic       has_entry;
    logic       has_status;
    logic [19:0] label;
    logic [2:0] exp_bits;
    logic       bottom;
    logic [7:0] ttl;
    cls_t       label_class;
    logic [3:0] entry_index;
    status_t    status;
    logic [4:0] label_count;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  function automatic cls_t classify(input logic [19:0] label);
    cls_t c;
    case (label)
      20'd0:   c = CLS_IPV4_NULL;
      20'd1:   c = CLS_RTR_ALERT;
      20'd2:   c = CLS_IPV6_NULL;
      20'd3:   c = CLS_IMPL_NULL;
      default: c = CLS_OTHER;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mlsp_front.sv
// Front end: gathers bytes into stack words, decodes them, and builds queue jobs.
`default_nettype none
module mlsp_front #(
  parameter int MAX_LABELS = mlsp_pkg::MAX_LABELS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [4:0]    cfg_wdata,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  output mlsp_pkg::push_t    push
);

  localparam int CNT_W = $clog2(MAX_LABELS + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  logic [4:0]       max_depth;
  logic [1:0]       byte_phase, byte_phase_next;
  logic [23:0]      partial_word, partial_word_next;
  logic [CNT_W-1:0] entries_seen, entries_seen_next;
  logic             stack_done, stack_done_next;
  logic             stack_full, stack_full_next;
  logic [2:0]       bytes_seen, bytes_seen_next;

  logic [LIM_W-1:0] depth_cfg, lim;
  logic [31:0]      word;
  logic             entry_fire;
  mlsp_pkg::status_t st;

  // Clamp the configured depth into 1..MAX_LABELS.
  always_comb begin
    depth_cfg = LIM_W'(max_depth);
    if (max_depth == 5'd0) begin
      lim = LIM_W'(1);
    end else if (depth_cfg > LIM_W'(MAX_LABELS)) begin
      lim = LIM_W'(MAX_LABELS);
    end else begin
      lim = depth_cfg;
    end
  end

  assign word = {partial_word, data_byte};

  always_comb begin
    byte_phase_next   = byte_phase;
    partial_word_next = partial_word;
    entries_seen_next = entries_seen;
    stack_done_next   = stack_done;
    stack_full_next   = stack_full;
    bytes_seen_next   = (bytes_seen < 3'd4) ? bytes_seen + 3'd1 : bytes_seen;
    entry_fire        = 1'b0;
    if (!stack_done && !stack_full) begin
      if (byte_phase != 2'd3) begin
        partial_word_next = {partial_word[15:0], data_byte};
        byte_phase_next   = byte_phase + 2'd1;
      end else begin
        byte_phase_next   = 2'd0;
        partial_word_next = '0;
        if (LIM_W'(entries_seen) >= lim) begin
          stack_full_next = 1'b1;
        end else begin
          entry_fire        = 1'b1;
          entries_seen_next = entries_seen + CNT_W'(1);
          if (word[8]) begin
            stack_done_next = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (bytes_seen_next < 3'd4) begin
      st = mlsp_pkg::ST_TOO_SHORT;
    end else if (stack_done_next) begin
      st = mlsp_pkg::ST_COMPLETE;
    end else if (stack_full_next) begin
      st = mlsp_pkg::ST_TOO_DEEP;
    end else begin
      st = mlsp_pkg::ST_TRUNCATED;
    end
  end

  always_comb begin
    push.push            = accept && (entry_fire || last_byte);
    push.cmd.has_entry   = entry_fire;
    push.cmd.has_status  = last_byte;
    push.cmd.label       = word[31:12];
    push.cmd.exp_bits    = word[11:9];
    push.cmd.bottom      = word[8];
    push.cmd.ttl         = word[7:0];
    push.cmd.label_class = mlsp_pkg::classify(word[31:12]);
    push.cmd.entry_index = 4'(entries_seen);
    push.cmd.status      = st;
    push.cmd.label_count = 5'(entries_seen_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_depth    <= mlsp_pkg::MAX_DEPTH_RST;
      byte_phase   <= '0;
      partial_word <= '0;
      entries_seen <= '0;
      stack_done   <= 1'b0;
      stack_full   <= 1'b0;
      bytes_seen   <= '0;
    end else begin
      if (cfg_we) begin
        max_depth <= cfg_wdata;
      end
      if (accept) begin
        if (last_byte) begin
          // End of frame: clear all frame state.
          byte_phase   <= '0;
          partial_word <= '0;
          entries_seen <= '0;
          stack_done   <= 1'b0;
          stack_full   <= 1'b0;
          bytes_seen   <= '0;
        end else begin
          byte_phase   <= byte_phase_next;
          partial_word <= partial_word_next;
          entries_seen <= entries_seen_next;
          stack_done   <= stack_done_next;
          stack_full   <= stack_full_next;
          bytes_seen   <= bytes_seen_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/mlsp_back.sv
// Back end: job queue and the serializer that sends entry and status words.
`default_nettype none
module mlsp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mlsp_pkg::push_t               push,
  output logic                               q_ready,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [mlsp_pkg::DATA_W-1:0]        m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tuser
);

  localparam int QA_W = $clog2(mlsp_pkg::Q_DEPTH);

  mlsp_pkg::cmd_t q [mlsp_pkg::Q_DEPTH];
  logic [QA_W-1:0] wr_ptr, rd_ptr;
  logic [QA_W:0]   count;
  logic            second;
  logic            send_entry, pop, out_acc;
  mlsp_pkg::cmd_t  head;

  assign q_ready       = (count != (QA_W + 1)'(mlsp_pkg::Q_DEPTH));
  assign head          = q[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign send_entry    = head.has_entry && !second;
  // Drop the job once its final word goes out.
  assign pop           = out_acc && !(send_entry && head.has_status);

  always_comb begin
    if (send_entry) begin
      m_axis_tuser = mlsp_pkg::KIND_ENTRY;
      m_axis_tlast = !head.has_status;
      m_axis_tdata = {2'b00, head.label_count, mlsp_pkg::ST_COMPLETE, head.entry_index,
                      head.label_class, head.ttl, head.bottom, head.exp_bits, head.label};
    end else begin
      m_axis_tuser = mlsp_pkg::KIND_STATUS;
      m_axis_tlast = 1'b1;
      m_axis_tdata = {2'b00, head.label_count, head.status, 4'd0,
                      mlsp_pkg::CLS_IPV4_NULL, 8'd0, 1'b0, 3'd0, 20'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (push.push && q_ready) begin
      q[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      second <= 1'b0;
    end else begin
      if (push.push && q_ready) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
        second <= 1'b0;
      end else if (out_acc) begin
        second <= 1'b1;
      end
      count <= count + (QA_W + 1)'(push.push && q_ready) - (QA_W + 1)'(pop);
    end
  end

endmodule
`default_nettype wire

// File: hdl/mpls_label_stack_parser_unit.sv
// Throughput: one byte per cycle while the four-job queue has room; jobs enter it
// as their bytes are accepted. A frame's last byte that also closes a stack word
// yields two words, both sent from the queue that lies between front and back.
// Reset (rst, synchronous): clears frame state and the queue, max_depth returns to 16.
// Top level of the MPLS label stack parser.
`default_nettype none
module mpls_label_stack_parser_unit #(
  parameter int MAX_LABELS = mlsp_pkg::MAX_LABELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [4:0]                    cfg_wdata,      // max_depth
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // data_byte
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // label[19:0] exp_bits[22:20] bottom[23] ttl[31:24] label_class[34:32]
  // entry_index[38:35] status[40:39] label_count[45:41] zero[47:46]
  output logic [mlsp_pkg::DATA_W-1:0]        m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tuser    // kind
);

  mlsp_pkg::push_t push;
  logic q_ready;

  assign s_axis_tready = q_ready;

  mlsp_front #(
    .MAX_LABELS(MAX_LABELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (s_axis_tvalid && q_ready),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .push      (push)
  );

  mlsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .q_ready       (q_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("status word without tlast");

  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with nothing to send");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("queue not empty after reset");

  a_entry_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[40:39] == 2'd0)
    else $error("entry word carries a status");
`endif

endmodule
`default_nettype wire
